// File: sv/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Tile card row renderer package
// Shared constants, register indexes and the controller command bundle.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int PATTERN_ENTRIES  = 512;
  localparam int ROWS_PER_PATTERN = 8;
  localparam int MEM_ROWS         = PATTERN_ENTRIES * ROWS_PER_PATTERN;
  localparam int MEM_AW           = $clog2(MEM_ROWS);

  localparam int ADDR_W  = 12;
  localparam int ROW_W   = 8;
  localparam int CARD_W  = 16;
  localparam int PAT_W   = 9;
  localparam int LINE_W  = 3;
  localparam int COLOR_W = 4;
  localparam int NUM_PX  = 8;

  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  localparam logic [IDX_W-1:0] REG_FG_BG_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STACK_COLOR_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_STACK_COLOR_B = 3'd2;
  localparam logic [IDX_W-1:0] REG_STACK_COLOR_C = 3'd3;
  localparam logic [IDX_W-1:0] REG_STACK_COLOR_D = 3'd4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CARD = 1'b1;

  localparam logic [LINE_W-1:0] LAST_LINE = 3'd7;
  localparam logic [PAT_W-1:0]  PAT_MASK  = 9'h13F;

  typedef struct packed {
    logic              load_we;
    logic              card_we;
    logic              advance;
    logic [LINE_W-1:0] issue_line;
  } tcr_cmd_t;

endpackage

// File: sv/tcr_ctrl.sv
// ----------------------------------------------------------------------------
// Tile card row renderer controller
// Sequences the eight line reads of a card and the two-stage output pipe.
// ----------------------------------------------------------------------------
module tcr_ctrl
  import tcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tuser,
  output logic     s_tready,
  input  logic     m_tready,
  output logic     m_tvalid,
  output tcr_cmd_t cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t            state;
  logic [LINE_W-1:0] line_cnt;
  logic              rd_valid;
  logic              out_valid;
  logic              accept;
  logic              advance;
  logic              issue;

  assign s_tready = (state == IDLE) && !rd_valid;
  assign accept   = s_tvalid && s_tready;
  assign advance  = !out_valid || m_tready;
  assign issue    = (state == RUN);
  assign m_tvalid = out_valid;

  assign cmd.load_we    = accept && (s_tuser == KIND_LOAD);
  assign cmd.card_we    = accept && (s_tuser == KIND_CARD);
  assign cmd.advance    = advance;
  assign cmd.issue_line = line_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      line_cnt  <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= rd_valid;
        rd_valid  <= issue;
      end
      case (state)
        IDLE: begin
          if (cmd.card_we) begin
            state    <= RUN;
            line_cnt <= '0;
          end
        end
        RUN: begin
          if (advance) begin
            line_cnt <= line_cnt + 3'd1;
            if (line_cnt == LAST_LINE) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: sv/tcr_datapath.sv
// ----------------------------------------------------------------------------
// Tile card row renderer datapath
// Pattern memory, card decode, color stack and the line output register.
// ----------------------------------------------------------------------------
module tcr_datapath
  import tcr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  tcr_cmd_t                 cmd,
  input  logic [ADDR_W-1:0]        pattern_address,
  input  logic [ROW_W-1:0]         pattern_row,
  input  logic [CARD_W-1:0]        card_word,
  input  logic                     row_start,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic [LINE_W-1:0]        out_line,
  output logic [NUM_PX-1:0][COLOR_W-1:0] out_px,
  output logic                     out_last
);

  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_ROWS);

  logic [ROW_W-1:0] mem [MEM_ROWS];

  logic                     fg_bg_mode;
  logic [3:0][COLOR_W-1:0]  stack_color;
  logic [1:0]               stack_pointer;

  logic [PAT_W-1:0]   pat;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic               squares;
  logic [COLOR_W-1:0] q0;
  logic [2:0]         q1;
  logic [2:0]         q2;
  logic [2:0]         q3;

  logic [ROW_W-1:0]   rdata;
  logic               rd_inrange;
  logic [LINE_W-1:0]  rd_line;

  logic [1:0]         sp_eff;
  logic [COLOR_W-1:0] stk;
  logic [PAT_W-1:0]   pat_raw;
  logic               sq_new;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_ok;
  logic               wr_ok;
  logic [ROW_W-1:0]   bits;

  assign sp_eff  = row_start ? 2'd0 : stack_pointer;
  assign stk     = stack_color[sp_eff];
  assign pat_raw = card_word[11:3];
  assign sq_new  = (card_word[12:11] == 2'b10);
  assign rd_addr = {pat, cmd.issue_line};
  assign rd_ok   = {1'b0, rd_addr} < MEM_LIMIT;
  assign wr_ok   = {1'b0, pattern_address} < MEM_LIMIT;
  assign bits    = rd_inrange ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_bg_mode    <= 1'b0;
      stack_color   <= '0;
      stack_pointer <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG_BG_MODE:    fg_bg_mode     <= cfg_data[0];
          REG_STACK_COLOR_A: stack_color[0] <= cfg_data;
          REG_STACK_COLOR_B: stack_color[1] <= cfg_data;
          REG_STACK_COLOR_C: stack_color[2] <= cfg_data;
          REG_STACK_COLOR_D: stack_color[3] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.card_we) begin
        if (!fg_bg_mode && !sq_new) begin
          stack_pointer <= sp_eff + {1'b0, card_word[13]};
        end else begin
          stack_pointer <= sp_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.card_we) begin
      pat <= (pat_raw[8] || fg_bg_mode) ? (pat_raw & PAT_MASK) : pat_raw;
      q1  <= card_word[5:3];
      q2  <= card_word[8:6];
      q3  <= {card_word[13], card_word[10:9]};
      q0  <= (card_word[2:0] == 3'd7) ? stk : {1'b0, card_word[2:0]};
      if (fg_bg_mode) begin
        fg      <= {1'b0, card_word[2:0]};
        bg      <= {card_word[11], card_word[13], card_word[9:8]};
        squares <= 1'b0;
      end else begin
        fg      <= {card_word[12], card_word[2:0]};
        bg      <= stk;
        squares <= sq_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      mem[pattern_address[MEM_AW-1:0]] <= pattern_row;
    end
    if (cmd.advance) begin
      rdata      <= mem[rd_addr[MEM_AW-1:0]];
      rd_inrange <= rd_ok;
      rd_line    <= cmd.issue_line;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      out_line <= rd_line;
      out_last <= (rd_line == LAST_LINE);
      for (int i = 0; i < NUM_PX; i++) begin
        if (squares) begin
          if (rd_line[2]) begin
            out_px[i] <= (i >= NUM_PX / 2) ? {1'b0, q3} : {1'b0, q2};
          end else begin
            out_px[i] <= (i >= NUM_PX / 2) ? {1'b0, q1} : q0;
          end
        end else begin
          out_px[i] <= bits[NUM_PX-1-i] ? fg : bg;
        end
      end
    end
  end

endmodule

// File: sv/tile_card_row_renderer_core.sv
// ----------------------------------------------------------------------------
// Tile card row renderer
// Background tile renderer: pattern row loads and eight-line card rendering.
// ----------------------------------------------------------------------------
// The slave stream carries load and card items, selected by s_tuser. A load
// transfer writes one pattern row in its cycle and yields nothing. A card
// transfer yields eight line transfers on the master stream, line 0 first,
// with m_tlast set on line 7.
// The first line reaches the output once the card is registered, its line 0
// is read from the pattern memory and the output register is loaded; further
// lines follow one per cycle while m_tready stays high. A card holds the
// input until its eight line reads have gone through the single read port
// of the pattern memory and the read stage has emptied.
// Loads are taken at one per cycle between cards.
// When the receiver stalls, the line in the output register and the line
// read behind it both hold, and the memory read is not repeated until the
// pipe moves again. The last line may wait in the output register while the
// next item is already taken.
// Reset clears the configuration registers, the stack pointer and the
// pipeline; pattern memory content is not cleared. Configuration writes are
// taken at once through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module tile_card_row_renderer_core
  import tcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // pattern_address, pattern_row, card_word, row_start, zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // kind
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // line_index, pixel_0 .. pixel_7, zero fill
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  tcr_cmd_t                      cmd;
  logic [LINE_W-1:0]             out_line;
  logic [NUM_PX-1:0][COLOR_W-1:0] out_px;
  logic                          out_last;

  tcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  tcr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .pattern_address (s_tdata[11:0]),
    .pattern_row     (s_tdata[19:12]),
    .card_word       (s_tdata[35:20]),
    .row_start       (s_tdata[36]),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_line        (out_line),
    .out_px          (out_px),
    .out_last        (out_last)
  );

  assign m_tdata = {5'd0, out_px[7], out_px[6], out_px[5], out_px[4],
                    out_px[3], out_px[2], out_px[1], out_px[0], out_line};
  assign m_tlast = out_last;

`ifndef ASSERT_OFF
  a_card_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("input taken right after a card transfer");

  a_lines_continue: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap between lines of one card");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
    else $error("line index out of order");

  a_last_is_line7: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[2:0] == LAST_LINE))
    else $error("last flag on a line other than the last");
`endif

endmodule

// File: bench/tile_render_monitor.sv
// ----------------------------------------------------------------------------
// Tile render monitor
// Watches the configuration port and both streams of the tile card row
// renderer. It keeps its own copy of pattern memory, the color stack and the
// mode, works out the eight lines that each accepted card must produce, and
// compares every output transfer field by field with the oldest pending line.
// ----------------------------------------------------------------------------
module tile_render_monitor
  import tcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic                m_tlast,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  errors,
  output int                  lines_owed,
  output int                  loads_seen,
  output int                  cards_seen,
  output int                  lines_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_LSB    = ADDR_W;
  localparam int CARD_LSB   = ROW_LSB + ROW_W;
  localparam int RSTART_BIT = CARD_LSB + CARD_W;

  typedef struct packed {
    logic [LINE_W-1:0]                line;
    logic [NUM_PX-1:0][COLOR_W-1:0]   px;
    logic                             last;
  } line_t;

  logic [ROW_W-1:0]   pat_rows [MEM_ROWS];
  logic [COLOR_W-1:0] stack_colors [4];
  logic [1:0]         stack_ptr;
  logic               fgbg_mode;
  line_t              pending_lines [$];

  function automatic void render_card(input logic [CARD_W-1:0] card, input logic rs);
    logic [PAT_W-1:0]   pat;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] quad [4];
    logic [ROW_W-1:0]   bits;
    logic               squares;
    line_t              e;
    if (rs) stack_ptr = 2'd0;
    pat = card[11:3];
    if (pat > 9'hFF || fgbg_mode) pat = pat & PAT_MASK;
    fg = {1'b0, card[2:0]};
    bg = '0;
    squares = 1'b0;
    for (int q = 0; q < 4; q++) quad[q] = '0;
    if (!fgbg_mode) begin
      fg[3] = card[12];
      bg = stack_colors[stack_ptr];
      squares = (card[12:11] == 2'b10);
      if (squares) begin
        quad[0] = (card[2:0] == 3'd7) ? bg : {1'b0, card[2:0]};
        quad[1] = {1'b0, card[5:3]};
        quad[2] = {1'b0, card[8:6]};
        quad[3] = {1'b0, card[13], card[10:9]};
      end else begin
        stack_ptr = stack_ptr + {1'b0, card[13]};
      end
    end else begin
      bg = {card[11], card[13], card[9:8]};
    end
    for (int ln = 0; ln < 8; ln++) begin
      bits = squares ? '0 : pat_rows[{pat, ln[2:0]}];
      e.line = ln[2:0];
      e.last = (ln == 7);
      for (int p = 0; p < NUM_PX; p++) begin
        if (squares) e.px[p] = quad[(ln >= 4 ? 2 : 0) + (p >= 4 ? 1 : 0)];
        else e.px[p] = bits[7-p] ? fg : bg;
      end
      pending_lines.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    line_t got;
    line_t want;
    int    bad;
    bad = 0;
    if (rst) begin
      stack_ptr = 2'd0;
      fgbg_mode = 1'b0;
      for (int i = 0; i < 4; i++) stack_colors[i] = '0;
      pending_lines.delete();
      errors     <= 0;
      loads_seen <= 0;
      cards_seen <= 0;
      lines_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG_BG_MODE:    fgbg_mode = cfg_data[0];
          REG_STACK_COLOR_A: stack_colors[0] = cfg_data;
          REG_STACK_COLOR_B: stack_colors[1] = cfg_data;
          REG_STACK_COLOR_C: stack_colors[2] = cfg_data;
          REG_STACK_COLOR_D: stack_colors[3] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_LOAD) begin
          if (s_tdata[ADDR_W-1:0] < MEM_ROWS)
            pat_rows[s_tdata[ADDR_W-1:0]] = s_tdata[ROW_LSB +: ROW_W];
          loads_seen <= loads_seen + 1;
        end else begin
          render_card(s_tdata[CARD_LSB +: CARD_W], s_tdata[RSTART_BIT]);
          cards_seen <= cards_seen + 1;
        end
      end
      if (m_tvalid && m_tready) begin
        got.line = m_tdata[LINE_W-1:0];
        for (int p = 0; p < NUM_PX; p++) got.px[p] = m_tdata[LINE_W + COLOR_W*p +: COLOR_W];
        got.last = m_tlast;
        lines_seen <= lines_seen + 1;
        if (pending_lines.size() == 0) begin
          $display("%0t: line transfer with nothing expected, got data %h last %b",
                   $time, m_tdata, m_tlast);
          bad++;
        end else begin
          want = pending_lines.pop_front();
          if (got.line !== want.line) begin
            $display("%0t: line index expected %0d, got %0d", $time, want.line, got.line);
            bad++;
          end
          for (int p = 0; p < NUM_PX; p++) begin
            if (got.px[p] !== want.px[p]) begin
              $display("%0t: line %0d pixel %0d expected %h, got %h",
                       $time, want.line, p, want.px[p], got.px[p]);
              bad++;
            end
          end
          if (got.last !== want.last) begin
            $display("%0t: line %0d last flag expected %b, got %b",
                     $time, want.line, want.last, got.last);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    lines_owed <= pending_lines.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Tile card row renderer testbench
// Drives pattern loads and card items into the renderer under several color
// stack and mode settings, with random gaps on both streams, one gap-free
// stretch and one long output stall. A separate monitor predicts and checks
// every output line; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
  import tcr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IDX_W-1:0] REG_NONE = REG_STACK_COLOR_D + 3'd1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  int errors;
  int lines_owed;
  int loads_seen;
  int cards_seen;
  int lines_seen;

  bit               steady = 1'b0;
  bit               hold_out = 1'b0;
  logic             cur_mode = 1'b0;
  bit               row_written [MEM_ROWS];
  logic [PAT_W-1:0] pat_pool [8];
  int               n_items = 0;
  int               n_settings = 0;

  tile_card_row_renderer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tile_render_monitor render_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .lines_owed (lines_owed),
    .loads_seen (loads_seen),
    .cards_seen (cards_seen),
    .lines_seen (lines_seen)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Timed out with %0d lines still owed.", lines_owed);
    $display("RESULT: ERROR");
    $finish;
  end

  // The valid stays high after a transfer so that back-to-back items never
  // drop and raise it within one step.
  task automatic send(input logic kind, input logic [ADDR_W-1:0] addr,
                      input logic [ROW_W-1:0] row, input logic [CARD_W-1:0] card,
                      input logic rs);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_DATA_W-ADDR_W-ROW_W-CARD_W-1){1'b0}}, rs, card, row, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic send_load(input logic [ADDR_W-1:0] addr, input logic [ROW_W-1:0] row);
    row_written[addr] = 1'b1;
    send(KIND_LOAD, addr, row, CARD_W'($urandom), 1'($urandom));
  endtask

  // Rows a card draws from are loaded first; no unwritten row is shown.
  task automatic send_card(input logic [CARD_W-1:0] card, input logic rs);
    logic [PAT_W-1:0]  pat;
    logic [ADDR_W-1:0] a;
    pat = card[11:3];
    if (pat > 9'hFF || cur_mode) pat = pat & PAT_MASK;
    if (cur_mode || card[12:11] != 2'b10) begin
      for (int ln = 0; ln < 8; ln++) begin
        a = {pat, ln[2:0]};
        if (!row_written[a]) send_load(a, ROW_W'($urandom));
      end
    end
    send(KIND_CARD, ADDR_W'($urandom), ROW_W'($urandom), card, rs);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lines_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FG_BG_MODE) cur_mode = val[0];
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] mode_val, input logic [CFG_W-1:0] ca,
                               input logic [CFG_W-1:0] cb, input logic [CFG_W-1:0] cc,
                               input logic [CFG_W-1:0] cd);
    write_reg(REG_FG_BG_MODE, mode_val);
    write_reg(REG_STACK_COLOR_A, ca);
    write_reg(REG_STACK_COLOR_B, cb);
    write_reg(REG_STACK_COLOR_C, cc);
    write_reg(REG_STACK_COLOR_D, cd);
    n_settings++;
  endtask

  task automatic random_item();
    logic [CARD_W-1:0] card;
    if ($urandom_range(0, 9) < 3) begin
      send_load(ADDR_W'($urandom), ROW_W'($urandom));
    end else begin
      card = CARD_W'($urandom);
      if ($urandom_range(0, 3) != 0) card[11:3] = pat_pool[$urandom_range(0, 7)];
      send_card(card, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin : line_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : item_source
    int               phase_end;
    logic [CFG_W-1:0] colors [4];
    logic             mode;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    pat_pool[0] = 9'h000;
    pat_pool[1] = 9'h1FF;
    for (int i = 2; i < 8; i++) pat_pool[i] = PAT_W'($urandom);

    // Stack mode; the upper bits of the mode value must be ignored.
    drain();
    set_registers(4'hE, 4'h3, 4'hF, 4'h0, 4'h9);
    write_reg(REG_NONE, 4'hF);
    send_load(12'd0, 8'h00);
    send_load(12'd1, 8'hFF);
    send_load(12'd2, 8'h80);
    send_load(12'd3, 8'h01);
    send_load(12'd4, 8'hAA);
    send_load(12'd5, 8'h55);
    send_load(12'd6, 8'h0F);
    send_load(12'd7, 8'hF0);
    send_load(12'hFFF, 8'hFF);
    send_card(16'h0000, 1'b1);
    for (int i = 0; i < 5; i++) send_card(16'h2000, 1'b0);
    send_card(16'h37FF, 1'b0);
    send_card(16'h1234, 1'b1);
    send_card(16'hFFFF, 1'b0);

    // Foreground/background mode.
    drain();
    write_reg(REG_FG_BG_MODE, 4'h1);
    send_card(16'hFFFF, 1'b1);
    send_card(16'h0600, 1'b0);
    send_card(16'h1000, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain();
      for (int i = 0; i < 4; i++) colors[i] = CFG_W'($urandom);
      if (p == 0) for (int i = 0; i < 4; i++) colors[i] = 4'hF;
      if (p == 3) for (int i = 0; i < 4; i++) colors[i] = 4'h0;
      mode = (p == 1 || p == 4);
      steady = (p == 2);
      set_registers({3'($urandom), mode}, colors[0], colors[1], colors[2], colors[3]);
      if (p == 3) hold_out = 1'b1;
      phase_end = n_items + 42;
      while (n_items < phase_end) random_item();
    end
    steady = 1'b0;
    drain();

    $display("Sent %0d items: %0d pattern loads and %0d cards, checked %0d lines.",
             n_items, loads_seen, cards_seen, lines_seen);
    $display("Used %0d register settings in both modes, with gaps, a gap-free stretch "
             , n_settings, "and a long output stall.");
    if (errors == 0 && lines_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
